// ===== rtl/core/psmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Planar shift/mask blit package
// Shared types, constants and helpers for the planar shift/mask blit block.
// ----------------------------------------------------------------------------
package psmb_pkg;

   localparam int WORD_W         = 16;
   localparam int PLANES         = 4;
   localparam int MAX_GROUPS_DEF = 64;
   localparam int QUEUE_DEPTH    = 2;
   localparam int GPR_W          = 7;
   localparam int PCNT_W         = 3;
   localparam int SHIFT_W        = 4;
   localparam int CSR_INDEX_W    = 3;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_COMBINE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LEFT_EDGE_MASK     = 3'd0,
      REG_RIGHT_EDGE_MASK    = 3'd1,
      REG_SHIFT_AMOUNT       = 3'd2,
      REG_GROUPS_PER_ROW     = 3'd3,
      REG_KEY_ENABLE         = 3'd4,
      REG_PLANE_COUNT        = 3'd5,
      REG_KEEP_UPDATE_ENABLE = 3'd6
   } csr_index_type;

   typedef struct packed {
      word_type              left_edge_mask;
      word_type              right_edge_mask;
      logic [SHIFT_W-1:0]    shift_amount;
      logic [GPR_W-1:0]      groups_per_row;
      logic                  key_enable;
      logic [PCNT_W-1:0]     plane_count;
      logic                  keep_update_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      left_edge_mask:     16'hFFFF,
      right_edge_mask:    16'hFFFF,
      shift_amount:       4'd0,
      groups_per_row:     7'd1,
      key_enable:         1'b0,
      plane_count:        3'd4,
      keep_update_enable: 1'b0
   };

   typedef struct packed {
      logic     cmd;
      word_type src_plane0;
      word_type src_plane1;
      word_type src_plane2;
      word_type src_plane3;
      word_type src_key;
      word_type dst_plane0;
      word_type dst_plane1;
      word_type dst_plane2;
      word_type dst_plane3;
      word_type dst_keep;
   } req_type;

   typedef struct packed {
      word_type out_plane0;
      word_type out_plane1;
      word_type out_plane2;
      word_type out_plane3;
      word_type out_keep;
      logic     row_end;
   } rsp_type;

   // One classified combine item as it travels from the front to the back.
   typedef struct packed {
      word_type [PLANES-1:0] src;
      word_type              vis;
      word_type [PLANES-1:0] dst;
      word_type              dst_keep;
      logic                  last;
   } work_type;

   // Upper word of the 32-bit window {hi, lo} shifted left by sh.
   function automatic word_type funnel(word_type hi, word_type lo,
                                       logic [SHIFT_W-1:0] sh);
      logic [2*WORD_W-1:0] win;
      win = {hi, lo} << sh;
      return win[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// ===== rtl/core/planar_shift_mask_blit_top.sv =====
// ----------------------------------------------------------------------------
// Planar shift/mask blit
// One row of a four-plane interleaved bitplane blit, one 16-pixel group per
// item, with source shift, edge masks, source keying and keep-word update.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the queue is not full, and gives
// one result item per combine item; a load item only primes the source window
// and restarts the row, and gives no result. An accepted combine item is
// written into the queue, then into the output register that drives rsp_data
// once the result side is not stalled. The rate is set by the front's window
// and group counter, which update once per item; a two-entry queue and an
// output register let the input side keep accepting while a result waits to
// be popped. Configuration registers must be written through the csr port
// only while no item is in flight; the user must see to this, the block does
// not. They take effect for the next item. Rows are cut at MAX_GROUPS groups.
// ----------------------------------------------------------------------------
module planar_shift_mask_blit_top #(
   parameter int MAX_GROUPS = psmb_pkg::MAX_GROUPS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   output logic                                     full,
   input  psmb_pkg::req_type                        req_data,
   output logic                                     empty,
   input  logic                                     pop,
   output psmb_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_we,
   input  logic [psmb_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  psmb_pkg::word_type                       csr_wdata
);
   import psmb_pkg::*;

   // Configuration registers, in the order of their indexes.
   cfg_type  cfg_ff, cfg_in;

   logic     accept;
   logic     work_push;
   work_type work_in;
   work_type work_head;
   logic     work_pop;
   logic     work_empty;
   logic     rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_LEFT_EDGE_MASK:     cfg_in.left_edge_mask     = csr_wdata;
            REG_RIGHT_EDGE_MASK:    cfg_in.right_edge_mask    = csr_wdata;
            REG_SHIFT_AMOUNT:       cfg_in.shift_amount       = csr_wdata[SHIFT_W-1:0];
            REG_GROUPS_PER_ROW:     cfg_in.groups_per_row     = csr_wdata[GPR_W-1:0];
            REG_KEY_ENABLE:         cfg_in.key_enable         = csr_wdata[0];
            REG_PLANE_COUNT:        cfg_in.plane_count        = csr_wdata[PCNT_W-1:0];
            REG_KEEP_UPDATE_ENABLE: cfg_in.keep_update_enable = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The queue's full flag throttles every item, loads included, so that
   // the window never runs ahead of an item that could not be queued.
   assign accept = push && !full;

   psmb_front #(
      .MAX_GROUPS (MAX_GROUPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .req       (req_data),
      .work_push (work_push),
      .work      (work_in)
   );

   psmb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in),
      .pop       (work_pop),
      .head_data (work_head),
      .full      (full),
      .empty     (work_empty)
   );

   psmb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_empty (work_empty),
      .work       (work_head),
      .work_pop   (work_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_data),
      .rsp_taken  (pop)
   );

   assign empty = !rsp_valid;

   a_shift_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == REG_SHIFT_AMOUNT))
         |=> (cfg_ff.shift_amount == $past(csr_wdata[SHIFT_W-1:0])))
      else $error("shift register write lost");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result item changed before it was popped");

endmodule

// ===== rtl/core/psmb_queue.sv =====
// ----------------------------------------------------------------------------
// Planar shift/mask blit work queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module psmb_queue #(
   parameter int DEPTH = psmb_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  psmb_pkg::work_type push_data,
   input  logic               pop,
   output psmb_pkg::work_type head_data,
   output logic               full,
   output logic               empty
);
   import psmb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   work_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule

// ===== rtl/core/psmb_front.sv =====
// ----------------------------------------------------------------------------
// Planar shift/mask blit front
// Accepts items, keeps the source window and group position, and turns each
// combine item into aligned source words and a visibility mask.
// ----------------------------------------------------------------------------
module psmb_front #(
   parameter int MAX_GROUPS = psmb_pkg::MAX_GROUPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  psmb_pkg::cfg_type  cfg,
   input  logic               accept,
   input  psmb_pkg::req_type  req,
   output logic               work_push,
   output psmb_pkg::work_type work
);
   import psmb_pkg::*;

   localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = $clog2(MAX_GROUPS + 1);
   localparam int WW = (CW > GPR_W) ? CW : GPR_W;

   word_type [PLANES-1:0] prev_src_ff, prev_src_in;
   word_type              prev_key_ff, prev_key_in;
   logic [IW-1:0]         idx_ff, idx_in;

   word_type [PLANES-1:0] src_word;
   word_type [PLANES-1:0] dst_word;
   logic [WW-1:0]         gpr_ext;
   logic [CW-1:0]         ng;
   logic [CW:0]           idx_next;
   logic                  last;
   logic                  is_load;
   word_type              vis;

   assign src_word = {req.src_plane3, req.src_plane2, req.src_plane1, req.src_plane0};
   assign dst_word = {req.dst_plane3, req.dst_plane2, req.dst_plane1, req.dst_plane0};
   assign is_load  = (req.cmd == CMD_LOAD);

   // Row length, with zero taken as one and large values saturated.
   always_comb begin
      gpr_ext = WW'(cfg.groups_per_row);
      if (gpr_ext == '0) begin
         ng = CW'(1);
      end else if (gpr_ext > WW'(MAX_GROUPS)) begin
         ng = CW'(MAX_GROUPS);
      end else begin
         ng = CW'(gpr_ext);
      end
   end

   assign idx_next = (CW + 1)'(idx_ff) + 1'b1;
   assign last     = (idx_next >= (CW + 1)'(ng));

   always_comb begin
      vis = '1;
      if (idx_ff == '0) begin
         vis = vis & cfg.left_edge_mask;
      end
      if (last) begin
         vis = vis & cfg.right_edge_mask;
      end
      if (cfg.key_enable) begin
         vis = vis & ~funnel(prev_key_ff, req.src_key, cfg.shift_amount);
      end
   end

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         work.src[p] = funnel(prev_src_ff[p], src_word[p], cfg.shift_amount);
      end
      work.vis      = vis;
      work.dst      = dst_word;
      work.dst_keep = req.dst_keep;
      work.last     = last;
   end

   assign work_push = accept && !is_load;

   always_comb begin
      prev_src_in = prev_src_ff;
      prev_key_in = prev_key_ff;
      idx_in      = idx_ff;
      if (accept) begin
         prev_src_in = src_word;
         prev_key_in = req.src_key;
         if (is_load || last) begin
            idx_in = '0;
         end else begin
            idx_in = IW'(idx_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_src_ff <= '0;
         prev_key_ff <= '0;
         idx_ff      <= '0;
      end else begin
         prev_src_ff <= prev_src_in;
         prev_key_ff <= prev_key_in;
         idx_ff      <= idx_in;
      end
   end

   a_load_restarts_row: assert property (@(posedge clock) disable iff (reset)
      (accept && is_load) |=> (idx_ff == '0))
      else $error("load did not restart the row");

endmodule

// ===== rtl/core/psmb_back.sv =====
// ----------------------------------------------------------------------------
// Planar shift/mask blit back
// Merges queued items into the destination planes and holds the result item.
// ----------------------------------------------------------------------------
module psmb_back (
   input  logic               clock,
   input  logic               reset,
   input  psmb_pkg::cfg_type  cfg,
   input  logic               work_empty,
   input  psmb_pkg::work_type work,
   output logic               work_pop,
   output logic               rsp_valid,
   output psmb_pkg::rsp_type  rsp,
   input  logic               rsp_taken
);
   import psmb_pkg::*;

   logic                  valid_ff, valid_in;
   rsp_type               rsp_ff, rsp_in;
   word_type [PLANES-1:0] merged;
   word_type              keep;

   assign keep     = ~work.vis;
   assign work_pop = !work_empty && (!valid_ff || rsp_taken);

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         if (PCNT_W'(p) < cfg.plane_count) begin
            merged[p] = (work.dst[p] & keep) | (work.src[p] & work.vis);
         end else begin
            merged[p] = work.dst[p];
         end
      end
      rsp_in.out_plane0 = merged[0];
      rsp_in.out_plane1 = merged[1];
      rsp_in.out_plane2 = merged[2];
      rsp_in.out_plane3 = merged[3];
      rsp_in.out_keep   = cfg.keep_update_enable ? (work.dst_keep & keep) : work.dst_keep;
      rsp_in.row_end    = work.last;
   end

   always_comb begin
      valid_in = valid_ff;
      if (work_pop) begin
         valid_in = 1'b1;
      end else if (rsp_taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule
